// ----- rtl/rau_pkg.sv -----
// Shared constants, codes and request/response types of the rational arithmetic unit.
`default_nettype none

package rau_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int MAG_W         = 2 * OPERAND_WIDTH;
   localparam int NUM_W         = MAG_W + 1;
   localparam int PROD_W        = 2 * OPERAND_WIDTH + 2;
   localparam int K_W           = $clog2(MAG_W + 1);
   localparam int GCD_STEPS     = 2 * MAG_W;
   localparam int RES_NUM_W     = 32;
   localparam int RES_DEN_W     = 31;
   localparam int NUM_SAT_W     = (NUM_W > RES_NUM_W + 1) ? NUM_W : RES_NUM_W + 1;
   localparam int DEN_SAT_W     = (MAG_W > RES_DEN_W) ? MAG_W : RES_DEN_W;

   localparam logic signed [NUM_SAT_W-1:0] NUM_MAX =
      {{(NUM_SAT_W - RES_NUM_W + 1){1'b0}}, {(RES_NUM_W - 1){1'b1}}};
   localparam logic signed [NUM_SAT_W-1:0] NUM_MIN =
      {{(NUM_SAT_W - RES_NUM_W + 1){1'b1}}, {(RES_NUM_W - 1){1'b0}}};
   localparam logic [DEN_SAT_W-1:0] DEN_MAX =
      {{(DEN_SAT_W - RES_DEN_W){1'b0}}, {RES_DEN_W{1'b1}}};

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_EQ  = 3'd4,
      OP_LT  = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0]                      operation;
      logic signed [OPERAND_WIDTH-1:0] left_num;
      logic signed [OPERAND_WIDTH-1:0] left_den;
      logic signed [OPERAND_WIDTH-1:0] right_num;
      logic signed [OPERAND_WIDTH-1:0] right_den;
   } req_type;

   typedef struct packed {
      logic signed [RES_NUM_W-1:0] result_num;
      logic [RES_DEN_W-1:0]        result_den;
      logic                        compare_true;
   } rsp_type;

   typedef struct packed {
      logic arith;
      logic neg;
      logic cmp;
   } side_type;

endpackage

`default_nettype wire

// ----- rtl/rau_gcd.sv -----
// Pipelined binary greatest common divisor, one reduction step per stage.
`default_nettype none

module rau_gcd import rau_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [MAG_W-1:0] in_u,
   input  logic [MAG_W-1:0] in_v,
   input  side_type         in_side,
   output logic             out_valid,
   output logic [MAG_W-1:0] out_g,
   output logic [MAG_W-1:0] out_u,
   output logic [MAG_W-1:0] out_v,
   output side_type         out_side
);

   typedef struct packed {
      logic [MAG_W-1:0] u;
      logic [MAG_W-1:0] v;
      logic [MAG_W-1:0] a;
      logic [MAG_W-1:0] d;
      logic [K_W-1:0]   k;
      side_type         side;
   } gstage_type;

   function automatic gstage_type gcd_step(input gstage_type s);
      gstage_type r;
      r = s;
      if ((s.u != '0) && (s.v != '0)) begin
         if (!s.u[0] && !s.v[0]) begin
            r.u = s.u >> 1;
            r.v = s.v >> 1;
            r.k = s.k + K_W'(1);
         end else if (!s.u[0]) begin
            r.u = s.u >> 1;
         end else if (!s.v[0]) begin
            r.v = s.v >> 1;
         end else if (s.u >= s.v) begin
            r.u = (s.u - s.v) >> 1;
         end else begin
            r.v = (s.v - s.u) >> 1;
         end
      end
      return r;
   endfunction

   logic [GCD_STEPS:0] valid_ff;
   gstage_type         pipe_ff [0:GCD_STEPS];
   gstage_type         step_in [0:GCD_STEPS-1];
   gstage_type         head_in;

   always_comb begin
      head_in.u    = in_u;
      head_in.v    = in_v;
      head_in.a    = in_u;
      head_in.d    = in_v;
      head_in.k    = '0;
      head_in.side = in_side;
      for (int i = 0; i < GCD_STEPS; i++) begin
         step_in[i] = gcd_step(pipe_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[GCD_STEPS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff[0] <= head_in;
         for (int i = 0; i < GCD_STEPS; i++) begin
            pipe_ff[i+1] <= step_in[i];
         end
      end
   end

   assign out_valid = valid_ff[GCD_STEPS];
   assign out_g     = (pipe_ff[GCD_STEPS].u | pipe_ff[GCD_STEPS].v) << pipe_ff[GCD_STEPS].k;
   assign out_u     = pipe_ff[GCD_STEPS].a;
   assign out_v     = pipe_ff[GCD_STEPS].d;
   assign out_side  = pipe_ff[GCD_STEPS].side;

endmodule

`default_nettype wire

// ----- rtl/rau_div.sv -----
// Pipelined restoring divider that divides two magnitudes by a common divisor.
`default_nettype none

module rau_div import rau_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [MAG_W-1:0] in_a,
   input  logic [MAG_W-1:0] in_d,
   input  logic [MAG_W-1:0] in_g,
   input  side_type         in_side,
   output logic             out_valid,
   output logic [MAG_W-1:0] out_qa,
   output logic [MAG_W-1:0] out_qd,
   output side_type         out_side
);

   typedef struct packed {
      logic [MAG_W-1:0] ra;
      logic [MAG_W-1:0] rd;
      logic [MAG_W-1:0] na;
      logic [MAG_W-1:0] nd;
      logic [MAG_W-1:0] qa;
      logic [MAG_W-1:0] qd;
      logic [MAG_W-1:0] g;
      side_type         side;
   } dstage_type;

   function automatic dstage_type div_step(input dstage_type s);
      dstage_type       r;
      logic [MAG_W:0]   ta;
      logic [MAG_W:0]   td;
      r    = s;
      ta   = {s.ra, s.na[MAG_W-1]};
      td   = {s.rd, s.nd[MAG_W-1]};
      r.na = s.na << 1;
      r.nd = s.nd << 1;
      if (ta >= {1'b0, s.g}) begin
         ta   = ta - {1'b0, s.g};
         r.qa = {s.qa[MAG_W-2:0], 1'b1};
      end else begin
         r.qa = {s.qa[MAG_W-2:0], 1'b0};
      end
      if (td >= {1'b0, s.g}) begin
         td   = td - {1'b0, s.g};
         r.qd = {s.qd[MAG_W-2:0], 1'b1};
      end else begin
         r.qd = {s.qd[MAG_W-2:0], 1'b0};
      end
      r.ra = ta[MAG_W-1:0];
      r.rd = td[MAG_W-1:0];
      return r;
   endfunction

   logic [MAG_W:0] valid_ff;
   dstage_type     pipe_ff [0:MAG_W];
   dstage_type     step_in [0:MAG_W-1];
   dstage_type     head_in;

   always_comb begin
      head_in.ra   = '0;
      head_in.rd   = '0;
      head_in.na   = in_a;
      head_in.nd   = in_d;
      head_in.qa   = '0;
      head_in.qd   = '0;
      head_in.g    = in_g;
      head_in.side = in_side;
      for (int i = 0; i < MAG_W; i++) begin
         step_in[i] = div_step(pipe_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[MAG_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff[0] <= head_in;
         for (int i = 0; i < MAG_W; i++) begin
            pipe_ff[i+1] <= step_in[i];
         end
      end
   end

   assign out_valid = valid_ff[MAG_W];
   assign out_qa    = pipe_ff[MAG_W].qa;
   assign out_qd    = pipe_ff[MAG_W].qd;
   assign out_side  = pipe_ff[MAG_W].side;

endmodule

`default_nettype wire

// ----- rtl/rational_arithmetic_unit_core.sv -----
// Top level of the rational arithmetic unit: products, gcd reduction and result formatting.
//
// Channel  Direction  Payload   Handshake
// req      in         req_type  req_valid / req_ready
// rsp      out        rsp_type  rsp_valid / rsp_ready
//
// A request can enter in every cycle unless a response waits; it passes through the
// product, operation, binary gcd and restoring divider stages and the response register.
// All stages move together and halt while a response waits on rsp_ready.
// Reset clears all valid bits; no requests are lost or repeated across a stall.
`default_nettype none

module rational_arithmetic_unit_core import rau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   function automatic logic signed [OPERAND_WIDTH:0] cmp_num(
      input logic signed [OPERAND_WIDTH-1:0] n,
      input logic signed [OPERAND_WIDTH-1:0] d
   );
      logic signed [OPERAND_WIDTH:0] r;
      if (n == '0) begin
         r = '0;
      end else if (d == '0) begin
         r = n[OPERAND_WIDTH-1] ? -(OPERAND_WIDTH+1)'(1) : (OPERAND_WIDTH+1)'(1);
      end else if (d[OPERAND_WIDTH-1]) begin
         r = -((OPERAND_WIDTH+1)'(n));
      end else begin
         r = (OPERAND_WIDTH+1)'(n);
      end
      return r;
   endfunction

   function automatic logic [OPERAND_WIDTH-1:0] cmp_den(
      input logic signed [OPERAND_WIDTH-1:0] n,
      input logic signed [OPERAND_WIDTH-1:0] d
   );
      logic [OPERAND_WIDTH-1:0] r;
      if (n == '0) begin
         r = OPERAND_WIDTH'(1);
      end else if (d == '0) begin
         r = '0;
      end else if (d[OPERAND_WIDTH-1]) begin
         r = OPERAND_WIDTH'(-d);
      end else begin
         r = OPERAND_WIDTH'(d);
      end
      return r;
   endfunction

   logic advance;

   logic                      s1_valid_ff;
   logic [2:0]                s1_op_ff;
   logic signed [MAG_W-1:0]   s1_ad_ff;
   logic signed [MAG_W-1:0]   s1_bc_ff;
   logic signed [MAG_W-1:0]   s1_ac_ff;
   logic signed [MAG_W-1:0]   s1_bd_ff;
   logic signed [PROD_W-1:0]  s1_lhs_ff;
   logic signed [PROD_W-1:0]  s1_rhs_ff;

   logic signed [OPERAND_WIDTH:0] ln_norm;
   logic signed [OPERAND_WIDTH:0] rn_norm;
   logic [OPERAND_WIDTH-1:0]      ld_norm;
   logic [OPERAND_WIDTH-1:0]      rd_norm;

   logic                    s2_valid_ff;
   logic                    s2_arith_ff;
   logic                    s2_cmp_ff;
   logic signed [NUM_W-1:0] s2_n_ff;
   logic signed [NUM_W-1:0] s2_m_ff;
   logic                    s2_arith_in;
   logic                    s2_cmp_in;
   logic signed [NUM_W-1:0] s2_n_in;
   logic signed [NUM_W-1:0] s2_m_in;

   logic [MAG_W-1:0] gcd_u;
   logic [MAG_W-1:0] gcd_v;
   side_type         gcd_side;

   logic             g_valid;
   logic [MAG_W-1:0] g_value;
   logic [MAG_W-1:0] g_a;
   logic [MAG_W-1:0] g_d;
   side_type         g_side;

   logic             d_valid;
   logic [MAG_W-1:0] d_qa;
   logic [MAG_W-1:0] d_qd;
   side_type         d_side;

   logic signed [NUM_SAT_W-1:0] num_wide;
   logic [DEN_SAT_W-1:0]        den_wide;
   rsp_type                     rsp_in;
   rsp_type                     rsp_data_ff;
   logic                        rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      ln_norm = cmp_num(req_data.left_num, req_data.left_den);
      ld_norm = cmp_den(req_data.left_num, req_data.left_den);
      rn_norm = cmp_num(req_data.right_num, req_data.right_den);
      rd_norm = cmp_den(req_data.right_num, req_data.right_den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff  <= req_data.operation;
         s1_ad_ff  <= MAG_W'(req_data.left_num * req_data.right_den);
         s1_bc_ff  <= MAG_W'(req_data.left_den * req_data.right_num);
         s1_ac_ff  <= MAG_W'(req_data.left_num * req_data.right_num);
         s1_bd_ff  <= MAG_W'(req_data.left_den * req_data.right_den);
         s1_lhs_ff <= PROD_W'(ln_norm * $signed({1'b0, rd_norm}));
         s1_rhs_ff <= PROD_W'(rn_norm * $signed({1'b0, ld_norm}));
         s2_arith_ff <= s2_arith_in;
         s2_cmp_ff   <= s2_cmp_in;
         s2_n_ff     <= s2_n_in;
         s2_m_ff     <= s2_m_in;
      end
   end

   always_comb begin
      s2_arith_in = 1'b0;
      s2_cmp_in   = 1'b0;
      s2_n_in     = '0;
      s2_m_in     = '0;
      case (s1_op_ff)
         OP_ADD: begin
            s2_arith_in = 1'b1;
            s2_n_in     = NUM_W'(s1_ad_ff) + NUM_W'(s1_bc_ff);
            s2_m_in     = NUM_W'(s1_bd_ff);
         end
         OP_SUB: begin
            s2_arith_in = 1'b1;
            s2_n_in     = NUM_W'(s1_ad_ff) - NUM_W'(s1_bc_ff);
            s2_m_in     = NUM_W'(s1_bd_ff);
         end
         OP_MUL: begin
            s2_arith_in = 1'b1;
            s2_n_in     = NUM_W'(s1_ac_ff);
            s2_m_in     = NUM_W'(s1_bd_ff);
         end
         OP_DIV: begin
            s2_arith_in = 1'b1;
            s2_n_in     = NUM_W'(s1_ad_ff);
            s2_m_in     = NUM_W'(s1_bc_ff);
         end
         OP_EQ: begin
            s2_cmp_in = (s1_lhs_ff == s1_rhs_ff);
         end
         OP_LT: begin
            s2_cmp_in = (s1_lhs_ff < s1_rhs_ff);
         end
         default: begin
            s2_arith_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      gcd_u = s2_n_ff[NUM_W-1] ? MAG_W'(-s2_n_ff) : MAG_W'(s2_n_ff);
      gcd_v = s2_m_ff[NUM_W-1] ? MAG_W'(-s2_m_ff) : MAG_W'(s2_m_ff);
      if (gcd_u == '0) begin
         gcd_v = MAG_W'(1);
      end
      gcd_side.arith = s2_arith_ff;
      gcd_side.neg   = s2_n_ff[NUM_W-1] ^ s2_m_ff[NUM_W-1];
      gcd_side.cmp   = s2_cmp_ff;
   end

   rau_gcd u_gcd (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_valid_ff),
      .in_u      (gcd_u),
      .in_v      (gcd_v),
      .in_side   (gcd_side),
      .out_valid (g_valid),
      .out_g     (g_value),
      .out_u     (g_a),
      .out_v     (g_d),
      .out_side  (g_side)
   );

   rau_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (g_valid),
      .in_a      (g_a),
      .in_d      (g_d),
      .in_g      (g_value),
      .in_side   (g_side),
      .out_valid (d_valid),
      .out_qa    (d_qa),
      .out_qd    (d_qd),
      .out_side  (d_side)
   );

   always_comb begin
      num_wide = d_side.neg ? -$signed(NUM_SAT_W'(d_qa)) : $signed(NUM_SAT_W'(d_qa));
      if (num_wide > NUM_MAX) begin
         num_wide = NUM_MAX;
      end else if (num_wide < NUM_MIN) begin
         num_wide = NUM_MIN;
      end
      den_wide = DEN_SAT_W'(d_qd);
      if (den_wide > DEN_MAX) begin
         den_wide = DEN_MAX;
      end
      rsp_in.result_num   = d_side.arith ? RES_NUM_W'(num_wide) : '0;
      rsp_in.result_den   = d_side.arith ? RES_DEN_W'(den_wide) : '0;
      rsp_in.compare_true = d_side.cmp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An infinite result is always reduced to plus or minus one over zero.
   a_inf_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_den == '0) |->
         (rsp_data.result_num == 32'sd1 || rsp_data.result_num == -32'sd1 ||
          rsp_data.result_num == '0))
      else $error("zero denominator with unreduced numerator");

   // A zero arithmetic result is always 0/1.
   a_zero_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_num == '0 && rsp_data.result_den != '0) |->
         (rsp_data.result_den == 31'd1))
      else $error("zero numerator not over one");

   // A true comparison carries no fraction.
   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.compare_true) |->
         (rsp_data.result_num == '0 && rsp_data.result_den == '0))
      else $error("comparison response carries a fraction");

   // While a response is held, the pipeline takes no request.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken during output stall");

endmodule

`default_nettype wire
